>>> rtl/fnpi_pkg.sv
// Package for the film negative inversion block: item types, config index codes,
// the lane pipeline depth and the 2^(2^-i) constant table. No dependencies.
package fnpi_pkg;

	typedef struct packed {
		logic [15:0] pixel_red;
		logic [15:0] pixel_green;
		logic [15:0] pixel_blue;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_red;
		logic [15:0] out_green;
		logic [15:0] out_blue;
	} out_item_t;

	typedef enum logic [2:0] {
		CFG_RED_EXP    = 3'd0,
		CFG_GREEN_EXP  = 3'd1,
		CFG_BLUE_EXP   = 3'd2,
		CFG_RED_GAIN   = 3'd3,
		CFG_GREEN_GAIN = 3'd4,
		CFG_BLUE_GAIN  = 3'd5
	} cfg_index_t;

	localparam int FRAC_BITS   = 16;
	// input reg, 16 log steps, product, exponent sum, 16 exp steps, scaling
	localparam int LANE_DEPTH  = 2 * FRAC_BITS + 4;

	localparam logic [15:0] RED_EXP_RST   = 16'd8356;
	localparam logic [15:0] GREEN_EXP_RST = 16'd6144;
	localparam logic [15:0] BLUE_EXP_RST  = 16'd5284;

	// bitwise integer square root, 64-bit
	function automatic logic [63:0] fnpi_isqrt(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bt;
		rem = v;
		res = '0;
		bt  = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (rem >= res + bt) begin
				rem = rem - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// 2^(2^-i) in Q1.30, i from 1, each from the previous by integer sqrt
	function automatic logic [30:0] fnpi_exp_const(input int i);
		logic [63:0] c;
		c = fnpi_isqrt(64'd1 << 61);
		for (int j = 1; j < i; j++) begin
			c = fnpi_isqrt(c << 30);
		end
		return c[30:0];
	endfunction

endpackage

>>> rtl/fnpi_cfg_regs.sv
// Configuration register file: exponents and log2 gains per channel.
// Depends on fnpi_pkg.
module fnpi_cfg_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [24:0] cfg_data,
	output logic [15:0] exp_red,
	output logic [15:0] exp_green,
	output logic [15:0] exp_blue,
	output logic [24:0] gain_red,
	output logic [24:0] gain_green,
	output logic [24:0] gain_blue
);
	import fnpi_pkg::*;

	logic [15:0] exp_red_q, exp_green_q, exp_blue_q;
	logic [24:0] gain_red_q, gain_green_q, gain_blue_q;

	// register writes; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_red_q    <= RED_EXP_RST;
			exp_green_q  <= GREEN_EXP_RST;
			exp_blue_q   <= BLUE_EXP_RST;
			gain_red_q   <= '0;
			gain_green_q <= '0;
			gain_blue_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_RED_EXP:    exp_red_q    <= cfg_data[15:0];
				CFG_GREEN_EXP:  exp_green_q  <= cfg_data[15:0];
				CFG_BLUE_EXP:   exp_blue_q   <= cfg_data[15:0];
				CFG_RED_GAIN:   gain_red_q   <= cfg_data;
				CFG_GREEN_GAIN: gain_green_q <= cfg_data;
				CFG_BLUE_GAIN:  gain_blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign exp_red    = exp_red_q;
	assign exp_green  = exp_green_q;
	assign exp_blue   = exp_blue_q;
	assign gain_red   = gain_red_q;
	assign gain_green = gain_green_q;
	assign gain_blue  = gain_blue_q;

endmodule

>>> rtl/fnpi_lane.sv
// One channel pipeline: log2 by squaring, exponent product, 2^x by constant
// multiplies, rounding and saturation. Depends on fnpi_pkg.
module fnpi_lane (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] x,
	input  logic [15:0] expo,
	input  logic [24:0] gain,
	output logic [15:0] y
);
	import fnpi_pkg::*;

	localparam int NB = FRAC_BITS;

	// log2 section
	logic [30:0]   ly_s   [0:NB];
	logic [NB-1:0] lf_s   [0:NB];
	logic [3:0]    ln_s   [0:NB];
	logic          zero_s [0:NB];

	logic [3:0] lead;
	always_comb begin
		lead = '0;
		for (int i = 1; i < 16; i++) begin
			if (x[i]) lead = 4'(i);
		end
	end

	// normalize mantissa to Q1.30
	always_ff @(posedge clk) begin
		if (en) begin
			ly_s[0]   <= 31'({15'd0, x} << (5'd30 - {1'b0, lead}));
			lf_s[0]   <= '0;
			ln_s[0]   <= lead;
			zero_s[0] <= (x == 16'd0);
		end
	end

	for (genvar g = 0; g < NB; g++) begin : g_log
		logic [61:0] sq;
		logic [31:0] sqt;
		assign sq  = 62'(ly_s[g]) * 62'(ly_s[g]);
		assign sqt = sq[61:30];
		// one fraction bit per stage
		always_ff @(posedge clk) begin
			if (en) begin
				ly_s[g+1]   <= sqt[31] ? sqt[31:1] : sqt[30:0];
				lf_s[g+1]   <= {lf_s[g][NB-2:0], sqt[31]};
				ln_s[g+1]   <= ln_s[g];
				zero_s[g+1] <= zero_s[g];
			end
		end
	end

	// product stage, round half up
	logic [19:0] lval;
	logic [35:0] prod;
	logic [23:0] p_s1;
	logic        zero_p_s1;
	assign lval = {ln_s[NB], lf_s[NB]};
	assign prod = 36'(expo) * 36'(lval) + 36'd2048;
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1      <= prod[35:12];
			zero_p_s1 <= zero_s[NB];
		end
	end

	// exponent sum and range checks
	logic signed [26:0] t;
	logic        [26:0] u;
	assign t = {{2{gain[24]}}, gain} - $signed({3'd0, p_s1});
	assign u = t + 27'sd2097152;

	logic [30:0]   er_s   [0:NB];
	logic [NB-1:0] ef_s   [0:NB];
	logic [5:0]    es_s   [0:NB];
	logic          sat_s  [0:NB];
	logic          clr_s  [0:NB];

	always_ff @(posedge clk) begin
		if (en) begin
			er_s[0]  <= 31'd1 << 30;
			ef_s[0]  <= u[15:0];
			es_s[0]  <= 6'd62 - u[21:16];
			sat_s[0] <= zero_p_s1 || (t >= 27'sd1048576);
			clr_s[0] <= !zero_p_s1 && (t < -27'sd2097152);
		end
	end

	// 2^f, one fraction bit per stage from the top
	for (genvar g = 0; g < NB; g++) begin : g_exp
		localparam logic [30:0] CK = fnpi_exp_const(g + 1);
		logic [61:0] mp;
		assign mp = 62'(er_s[g]) * 62'(CK);
		always_ff @(posedge clk) begin
			if (en) begin
				er_s[g+1]  <= ef_s[g][NB-1-g] ? mp[60:30] : er_s[g];
				ef_s[g+1]  <= ef_s[g];
				es_s[g+1]  <= es_s[g];
				sat_s[g+1] <= sat_s[g];
				clr_s[g+1] <= clr_s[g];
			end
		end
	end

	// scaling with round half up, then saturation
	logic [63:0] rr;
	logic [63:0] q;
	logic [15:0] y_q;
	assign rr = {33'd0, er_s[NB]} + (64'd1 << (es_s[NB] - 6'd1));
	assign q  = rr >> es_s[NB];
	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_s[NB])       y_q <= 16'hFFFF;
			else if (clr_s[NB])  y_q <= '0;
			else if (q > 64'd65535) y_q <= 16'hFFFF;
			else                 y_q <= q[15:0];
		end
	end
	assign y = y_q;

endmodule

>>> rtl/film_negative_pixel_inversion.sv
// Film negative inversion top level: three channel lanes side by side.
// Throughput: one item per cycle; the whole lane pipeline advances together
// and stalls only while the output register holds an item not yet taken.
// Reset: valid pipeline cleared, registers return to their default exponents
// and zero gains. Depends on fnpi_pkg, fnpi_cfg_regs, fnpi_lane.
module film_negative_pixel_inversion (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fnpi_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output fnpi_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [24:0]         cfg_data
);
	import fnpi_pkg::*;

	logic [15:0] exp_red, exp_green, exp_blue;
	logic [24:0] gain_red, gain_green, gain_blue;
	logic        en;
	logic [LANE_DEPTH-1:0] vld_q;
	logic [15:0] y_red, y_green, y_blue;

	assign cfg_ready = 1'b1;

	fnpi_cfg_regs u_cfg (
		.clk, .arst_n, .cfg_valid, .cfg_index, .cfg_data,
		.exp_red, .exp_green, .exp_blue, .gain_red, .gain_green, .gain_blue
	);

	// pipeline moves unless the final item is stalled
	assign en       = !vld_q[LANE_DEPTH-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LANE_DEPTH-2:0], in_valid};
		end
	end

	fnpi_lane u_red (
		.clk, .en, .x(in_item.pixel_red), .expo(exp_red), .gain(gain_red), .y(y_red)
	);
	fnpi_lane u_green (
		.clk, .en, .x(in_item.pixel_green), .expo(exp_green), .gain(gain_green),
		.y(y_green)
	);
	fnpi_lane u_blue (
		.clk, .en, .x(in_item.pixel_blue), .expo(exp_blue), .gain(gain_blue), .y(y_blue)
	);

	// merge lane results into one item
	assign out_valid          = vld_q[LANE_DEPTH-1];
	assign out_item.out_red   = y_red;
	assign out_item.out_green = y_green;
	assign out_item.out_blue  = y_blue;

	a_stall_only_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input blocked without output backpressure");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0])
		else $error("accepted item not in first stage");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid pipeline moved during stall");

endmodule

>>> test/tb.sv
// Testbench for film_negative_pixel_inversion: directed and random pixels, several
// register settings and handshake idling patterns, self-checking against its own predictor.
// Depends on fnpi_pkg and the film_negative_pixel_inversion RTL.
module tb;
	import fnpi_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [24:0] cfg_data;

	film_negative_pixel_inversion dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam int PIPE_WAIT   = LANE_DEPTH + 8;
	localparam int HOLD_CYCLES = 200;

	// predictor copy of the channel registers
	logic [15:0]        exp_reg [3];
	logic signed [24:0] gain_reg [3];
	logic [63:0]        root_tab [1:16];

	out_item_t   pending_pixels[$];
	int          errors;
	int          sent;
	int          received;
	int          send_idle_pct;
	int          recv_stall_pct;
	logic        hold_off;
	event        hold_ev;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Q4.16 log2 of a nonzero 16-bit sample
	function automatic logic [19:0] log2_sample(input logic [15:0] x);
		logic [63:0] y;
		logic [15:0] fr;
		int n;
		n = 0;
		fr = '0;
		for (int i = 1; i < 16; i++)
			if ((x >> i) != 0)
				n = i;
		y = 64'(x) << (30 - n);
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 30;
			fr = fr << 1;
			if (y >= 64'd2 << 30) begin
				y = y >> 1;
				fr[0] = 1'b1;
			end
		end
		return {n[3:0], fr};
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bt;
		res = '0;
		bt = 64'd1 << 62;
		while (bt > v)
			bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// 2^gain * x^(-exponent), saturated to 16 bits
	function automatic logic [15:0] invert_sample(input logic [15:0] x, input logic [15:0] e,
			input logic signed [24:0] g);
		logic [63:0] prod;
		logic [63:0] u;
		logic [63:0] r;
		logic [63:0] q;
		longint t;
		int k;
		int s;
		if (x == 0)
			return 16'hFFFF;
		prod = (64'(e) * 64'(log2_sample(x)) + 64'd2048) >> 12;
		t = longint'(g) - longint'(prod);
		if (t >= (longint'(16) << 16))
			return 16'hFFFF;
		if (t < -(longint'(32) << 16))
			return 16'h0000;
		u = 64'(t + (longint'(32) << 16));
		k = int'(u >> 16) - 32;
		r = 64'd1 << 30;
		for (int i = 1; i <= 16; i++)
			if (u[16 - i])
				r = (r * root_tab[i]) >> 30;
		s = 30 - k;
		q = (r + (64'd1 << (s - 1))) >> s;
		if (q > 64'hFFFF)
			q = 64'hFFFF;
		return q[15:0];
	endfunction

	function automatic out_item_t predict_pixel(input in_item_t p);
		out_item_t o;
		o.out_red   = invert_sample(p.pixel_red,   exp_reg[0], gain_reg[0]);
		o.out_green = invert_sample(p.pixel_green, exp_reg[1], gain_reg[1]);
		o.out_blue  = invert_sample(p.pixel_blue,  exp_reg[2], gain_reg[2]);
		return o;
	endfunction

	// random gaps on the sending side
	task automatic send_gap();
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	// valid stays up after acceptance; a gap or drain takes it down
	task automatic send_pixel(input in_item_t p);
		send_gap();
		in_valid <= 1'b1;
		in_item  <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_pixels = {pending_pixels, predict_pixel(p)};
		sent++;
		@(negedge clk);
	endtask

	function automatic in_item_t rand_pixel();
		in_item_t p;
		p = in_item_t'(48'({$urandom, $urandom}));
		return p;
	endfunction

	task automatic write_reg(input cfg_index_t idx, input logic [24:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx <= CFG_BLUE_EXP)
			exp_reg[idx] = val[15:0];
		else
			gain_reg[idx - CFG_RED_GAIN] = val;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (PIPE_WAIT) @(negedge clk);
	endtask

	task automatic set_channels(input logic [15:0] e0, e1, e2, input logic [24:0] g0, g1, g2);
		drain();
		write_reg(CFG_RED_EXP, 25'(e0));
		write_reg(CFG_GREEN_EXP, 25'(e1));
		write_reg(CFG_BLUE_EXP, 25'(e2));
		write_reg(CFG_RED_GAIN, g0);
		write_reg(CFG_GREEN_GAIN, g1);
		write_reg(CFG_BLUE_GAIN, g2);
		cfg_valid <= 1'b0;
	endtask

	// reset defaults: field extremes, zero input, single bits
	task automatic test_directed();
		in_item_t p;
		logic [15:0] vals [8] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF, 16'h8000,
			16'h7FFF, 16'd255};
		for (int i = 0; i < 8; i++) begin
			p.pixel_red = vals[i];
			p.pixel_green = vals[(i + 3) % 8];
			p.pixel_blue = vals[(i + 5) % 8];
			send_pixel(p);
		end
	endtask

	// zero exponent, overflow and underflow gains, register extremes
	task automatic test_special_settings();
		in_item_t p;
		set_channels(16'd0, 16'd0, 16'd0, 25'sd196608, 25'h0FFFFFF, 25'h1000000);
		for (int i = 0; i < 4; i++)
			send_pixel(rand_pixel());
		set_channels(16'hFFFF, 16'hFFFF, 16'hFFFF, 25'h0FFFFFF, 25'h1000000, 25'd0);
		p = '{16'd1, 16'd1, 16'd1};
		send_pixel(p);
		p = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
		send_pixel(p);
		p = '{16'd0, 16'd2, 16'd40};
		send_pixel(p);
		set_channels(16'd4096, 16'd2048, 16'd12288, 25'd16 << 16, 25'd1048575,
			25'h1E00000);
		for (int i = 0; i < 6; i++)
			send_pixel(rand_pixel());
	endtask

	// random pixels over random settings and idling phases
	task automatic test_random(input int n);
		logic [24:0] g [3];
		for (int ph = 0; ph < 4; ph++) begin
			for (int c = 0; c < 3; c++)
				g[c] = ($urandom_range(3) == 0) ? 25'($urandom) :
					25'($urandom_range(24 << 16)) - 25'(4 << 16);
			set_channels($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(16384)),
				16'($urandom_range(16384)), 16'($urandom), g[0], g[1], g[2]);
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			for (int i = 0; i < n / 4; i++)
				send_pixel(rand_pixel());
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// receiver blocked for a long run while pixels keep coming
	task automatic test_backpressure();
		drain();
		-> hold_ev;
		for (int i = 0; i < 60; i++)
			send_pixel(rand_pixel());
	endtask

	// long receiver hold-off, counted here
	initial begin
		hold_off = 1'b0;
		forever begin
			@(hold_ev);
			hold_off <= 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_off <= 1'b0;
		end
	end

	// receiver: random stalls plus long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_off) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			received++;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_item);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (out_item.out_red !== want.out_red) begin
					$display("%0t: out_red expected %0d got %0d", $time, want.out_red,
						out_item.out_red);
					errors++;
				end
				if (out_item.out_green !== want.out_green) begin
					$display("%0t: out_green expected %0d got %0d", $time, want.out_green,
						out_item.out_green);
					errors++;
				end
				if (out_item.out_blue !== want.out_blue) begin
					$display("%0t: out_blue expected %0d got %0d", $time, want.out_blue,
						out_item.out_blue);
					errors++;
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		clk = 1'b0;
		errors = 0;
		sent = 0;
		received = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		exp_reg[0] = RED_EXP_RST;
		exp_reg[1] = GREEN_EXP_RST;
		exp_reg[2] = BLUE_EXP_RST;
		for (int c = 0; c < 3; c++)
			gain_reg[c] = '0;
		root_tab[1] = int_sqrt(64'd1 << 61);
		for (int i = 2; i <= 16; i++)
			root_tab[i] = int_sqrt(root_tab[i - 1] << 30);
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_RED_EXP;
		cfg_data = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_special_settings();
		test_backpressure();
		test_random(860);
		drain();

		$display("Sent %0d pixels, checked %0d results, over several gain/exponent settings",
			sent, received);
		$display("and idle/stall phases including a long output hold-off.");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

>>> files.f
rtl/fnpi_pkg.sv
rtl/fnpi_cfg_regs.sv
rtl/fnpi_lane.sv
rtl/film_negative_pixel_inversion.sv
test/tb.sv
